// ----- sv/svmp_pkg.sv -----
// ============================================================================
// svmp_pkg
// Constants and the CORDIC arctangent table shared by the von Mises and
// principal stress engine.
// ============================================================================
`default_nettype none

package svmp_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int OUT_WIDTH     = 34;
    localparam int TOL_WIDTH     = 16;
    localparam int GUARD_BITS    = 56 - DATA_WIDTH;
    localparam int WORK_WIDTH    = 64;
    localparam int ANGLE_WIDTH   = 36;
    localparam int MAX_ROTATIONS = 20;
    localparam int ROT_CNT_WIDTH = $clog2(MAX_ROTATIONS + 1);
    localparam int CORDIC_STEPS  = 30;
    localparam int SQRT_STEPS    = 34;
    localparam int MUL_WIDTH     = 33;

    localparam logic [15:0] TOL_RESET = 16'd4;
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_PI = 36'd3373259426;
    localparam logic [MUL_WIDTH-1:0] GAIN_INV = 33'd652032874;

    // Pair codes for the off-diagonal term chosen for rotation.
    localparam logic [1:0] PAIR_XY = 2'd0;
    localparam logic [1:0] PAIR_XZ = 2'd1;
    localparam logic [1:0] PAIR_YZ = 2'd2;

    typedef logic signed [WORK_WIDTH-1:0] work_t;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:  r = 32'h3243F6A8;
            5'd1:  r = 32'h1DAC6705;
            5'd2:  r = 32'h0FADBAFC;
            5'd3:  r = 32'h07F56EA6;
            5'd4:  r = 32'h03FEAB76;
            5'd5:  r = 32'h01FFD55B;
            5'd6:  r = 32'h00FFFAAA;
            5'd7:  r = 32'h007FFF55;
            5'd8:  r = 32'h003FFFEA;
            5'd9:  r = 32'h001FFFFD;
            5'd10: r = 32'h000FFFFF;
            5'd11: r = 32'h0007FFFF;
            5'd12: r = 32'h0003FFFF;
            5'd13: r = 32'h0001FFFF;
            5'd14: r = 32'h0000FFFF;
            5'd15: r = 32'h00007FFF;
            5'd16: r = 32'h00003FFF;
            5'd17: r = 32'h00001FFF;
            5'd18: r = 32'h00000FFF;
            5'd19: r = 32'h000007FF;
            5'd20: r = 32'h000003FF;
            5'd21: r = 32'h000001FF;
            5'd22: r = 32'h000000FF;
            5'd23: r = 32'h0000007F;
            5'd24: r = 32'h0000003F;
            5'd25: r = 32'h0000001F;
            5'd26: r = 32'h0000000F;
            5'd27: r = 32'h00000008;
            5'd28: r = 32'h00000004;
            5'd29: r = 32'h00000002;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic logic [WORK_WIDTH-1:0] mag(input work_t v);
        return v[WORK_WIDTH-1] ? WORK_WIDTH'(-v) : WORK_WIDTH'(v);
    endfunction

endpackage

`default_nettype wire

// ----- sv/stress_von_mises_principal.sv -----
// ============================================================================
// stress_von_mises_principal
// Von Mises equivalent stress and sorted principal stresses of one symmetric
// 3D stress tensor, computed by a small sequencer around shared units.
// ============================================================================
// One input beat carries six signed Q16.16 stress components; one output beat
// returns the von Mises stress (unsigned Q18.16) and the three principal
// stresses in descending order (signed Q18.16). The block handles one tensor
// at a time and holds in_stall high from acceptance until its result is
// loaded into the output register, so a waiting result does not block the
// next input beat. The equivalent stress squares the stress differences and
// shears on the shared 33x33 multiplier, forms the radicand and takes a
// bit-pair square root. Each Jacobi rotation then takes a selection step,
// 30 CORDIC vectoring steps, a gain correction, 30 CORDIC rotation steps
// and two more gain corrections, all on one CORDIC datapath and the same
// multiplier. A last selection step ends the loop, the finish state loads
// the output register and the idle state takes the next beat. The loop runs
// at most 20 rotations, fewer once the largest off-diagonal term is at or
// below the tolerance, and a finished result waits in the finish state while
// out_stall holds back the previous result. The tolerance register is
// written through cfg_write_en/cfg_write_data and should only change while
// idle.
`default_nettype none

module stress_von_mises_principal
    import svmp_pkg::*;
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_write_en,
    input  wire [TOL_WIDTH-1:0]         cfg_write_data,
    input  wire                         in_valid,
    output logic                        in_stall,
    input  wire signed [DATA_WIDTH-1:0] normal_x,
    input  wire signed [DATA_WIDTH-1:0] normal_y,
    input  wire signed [DATA_WIDTH-1:0] normal_z,
    input  wire signed [DATA_WIDTH-1:0] shear_xy,
    input  wire signed [DATA_WIDTH-1:0] shear_yz,
    input  wire signed [DATA_WIDTH-1:0] shear_zx,
    output logic                        out_valid,
    input  wire                         out_stall,
    output logic [OUT_WIDTH-1:0]        equivalent_stress,
    output logic signed [OUT_WIDTH-1:0] principal_max,
    output logic signed [OUT_WIDTH-1:0] principal_mid,
    output logic signed [OUT_WIDTH-1:0] principal_min
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EQ     = 4'd1;
    localparam logic [3:0] S_SQINIT = 4'd2;
    localparam logic [3:0] S_SQRT   = 4'd3;
    localparam logic [3:0] S_SEL    = 4'd4;
    localparam logic [3:0] S_VEC    = 4'd5;
    localparam logic [3:0] S_GAIN_R = 4'd6;
    localparam logic [3:0] S_ROT    = 4'd7;
    localparam logic [3:0] S_GAIN_P = 4'd8;
    localparam logic [3:0] S_GAIN_Q = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    localparam logic [1:0] GPH_LO  = 2'd0;
    localparam logic [1:0] GPH_HI  = 2'd1;
    localparam logic [1:0] GPH_ADD = 2'd2;
    localparam logic [1:0] GPH_END = 2'd3;

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] gph_reg, gph_next;
    logic [ROT_CNT_WIDTH-1:0] rot_reg, rot_next;
    logic [TOL_WIDTH-1:0] tol_reg;
    logic [1:0] pair_reg, pair_next;

    logic signed [DATA_WIDTH-1:0] vx_reg, vy_reg, vz_reg, vxy_reg, vyz_reg, vzx_reg;
    work_t d0_reg, d1_reg, d2_reg, o01_reg, o02_reg, o12_reg;
    work_t d0_next, d1_next, d2_next, o01_next, o02_next, o12_next;
    work_t x_reg, y_reg, x_next, y_next, sum_reg, sum_next, pres_reg, pres_next;
    logic signed [ANGLE_WIDTH-1:0] z_reg, z_next;

    logic [2*MUL_WIDTH-1:0] prod_reg;
    logic [MUL_WIDTH-1:0] mul_a, mul_b;
    logic [94:0] accg_reg, accg_next;
    logic [66:0] accd_reg, accd_next;
    logic [65:0] accs_reg, accs_next;
    logic [67:0] rad_reg, rad_next;
    logic [35:0] rem_reg, rem_next;
    logic [OUT_WIDTH-1:0] root_reg, root_next;

    logic out_valid_reg;
    logic [OUT_WIDTH-1:0] eq_out_reg;
    logic signed [OUT_WIDTH-1:0] pmax_reg, pmid_reg, pmin_reg;

    // ---------------- combinational helpers ----------------
    logic signed [DATA_WIDTH:0] dif0, dif1, dif2;
    logic [MUL_WIDTH-1:0] eq_mag;
    logic signed [DATA_WIDTH-1:0] shear_sel;

    always_comb
    begin
        dif0 = (DATA_WIDTH+1)'(vx_reg) - (DATA_WIDTH+1)'(vy_reg);
        dif1 = (DATA_WIDTH+1)'(vy_reg) - (DATA_WIDTH+1)'(vz_reg);
        dif2 = (DATA_WIDTH+1)'(vz_reg) - (DATA_WIDTH+1)'(vx_reg);
        unique case (cnt_reg[2:0])
            3'd3:    shear_sel = vxy_reg;
            3'd4:    shear_sel = vyz_reg;
            default: shear_sel = vzx_reg;
        endcase
        unique case (cnt_reg[2:0])
            3'd0:    eq_mag = dif0[DATA_WIDTH] ? MUL_WIDTH'(-dif0) : MUL_WIDTH'(dif0);
            3'd1:    eq_mag = dif1[DATA_WIDTH] ? MUL_WIDTH'(-dif1) : MUL_WIDTH'(dif1);
            3'd2:    eq_mag = dif2[DATA_WIDTH] ? MUL_WIDTH'(-dif2) : MUL_WIDTH'(dif2);
            default: eq_mag = shear_sel[DATA_WIDTH-1]
                              ? MUL_WIDTH'(-(MUL_WIDTH'(shear_sel)))
                              : MUL_WIDTH'(shear_sel);
        endcase
    end

    // Gain correction source and result.
    work_t g_src, g_res;
    logic [WORK_WIDTH-1:0] g_mag;
    always_comb
    begin
        g_src = (state_reg == S_GAIN_Q) ? y_reg : x_reg;
        g_mag = mag(g_src);
        g_res = g_src[WORK_WIDTH-1] ? -work_t'(accg_reg[93:30]) : work_t'(accg_reg[93:30]);
    end

    // Shared multiplier operands.
    always_comb
    begin
        mul_a = eq_mag;
        mul_b = eq_mag;
        if (state_reg == S_GAIN_R || state_reg == S_GAIN_P || state_reg == S_GAIN_Q)
        begin
            mul_b = GAIN_INV;
            mul_a = (gph_reg == GPH_LO) ? {1'b0, g_mag[31:0]} : {1'b0, g_mag[63:32]};
        end
    end

    // Largest off-diagonal term.
    logic [WORK_WIDTH-1:0] m01, m02, m12, big;
    logic [1:0] pick;
    work_t a_sel, b_sel, fs_sel, vx0, vy0;
    always_comb
    begin
        m01 = mag(o01_reg);
        m02 = mag(o02_reg);
        m12 = mag(o12_reg);
        big  = m01;
        pick = PAIR_XY;
        if (m02 > big)
        begin
            big  = m02;
            pick = PAIR_XZ;
        end
        if (m12 > big)
        begin
            big  = m12;
            pick = PAIR_YZ;
        end
        unique case (pick)
            PAIR_XY: begin a_sel = d0_reg; b_sel = d1_reg; fs_sel = o01_reg; end
            PAIR_XZ: begin a_sel = d0_reg; b_sel = d2_reg; fs_sel = o02_reg; end
            default: begin a_sel = d1_reg; b_sel = d2_reg; fs_sel = o12_reg; end
        endcase
        vx0 = b_sel - a_sel;
        vy0 = fs_sel <<< 1;
    end

    // CORDIC step.
    work_t xs, ys;
    logic signed [ANGLE_WIDTH-1:0] atan_v;
    always_comb
    begin
        xs = x_reg >>> cnt_reg[4:0];
        ys = y_reg >>> cnt_reg[4:0];
        atan_v = ANGLE_WIDTH'(atan_entry(cnt_reg[4:0]));
    end

    // Diagonal update after vectoring.
    work_t dlo, dhi;
    always_comb
    begin
        dlo = (sum_reg - g_res) >>> 1;
        dhi = (sum_reg + g_res) >>> 1;
    end

    // Sorting and output rounding.
    work_t s0a, s1a, s1b, s2b, s0c, s1c;
    always_comb
    begin
        s0a = d0_reg; s1a = d1_reg;
        if (d1_reg > d0_reg)
        begin
            s0a = d1_reg; s1a = d0_reg;
        end
        s1b = s1a; s2b = d2_reg;
        if (d2_reg > s1a)
        begin
            s1b = d2_reg; s2b = s1a;
        end
        s0c = s0a; s1c = s1b;
        if (s1b > s0a)
        begin
            s0c = s1b; s1c = s0a;
        end
    end

    function automatic logic signed [OUT_WIDTH-1:0] round_out(input work_t d);
        work_t r;
        r = (d + (work_t'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
        if (r > work_t'((64'sd1 <<< (OUT_WIDTH - 1)) - 1))
            return {1'b0, {(OUT_WIDTH-1){1'b1}}};
        else if (r < -work_t'(64'sd1 <<< (OUT_WIDTH - 1)))
            return {1'b1, {(OUT_WIDTH-1){1'b0}}};
        return r[OUT_WIDTH-1:0];
    endfunction

    // Square root step.
    logic [37:0] rem_t, trial;
    always_comb
    begin
        rem_t = {rem_reg, rad_reg[67:66]};
        trial = {2'b00, root_reg, 2'b01};
    end

    logic in_acc, out_free;
    assign in_acc   = in_valid && (state_reg == S_IDLE);
    assign out_free = !(out_valid_reg && out_stall);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        gph_next   = gph_reg;
        rot_next   = rot_reg;
        pair_next  = pair_reg;
        d0_next = d0_reg; d1_next = d1_reg; d2_next = d2_reg;
        o01_next = o01_reg; o02_next = o02_reg; o12_next = o12_reg;
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        sum_next = sum_reg; pres_next = pres_reg;
        accg_next = accg_reg; accd_next = accd_reg; accs_next = accs_reg;
        rad_next = rad_reg; rem_next = rem_reg; root_next = root_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    d0_next  = work_t'(normal_x) <<< GUARD_BITS;
                    d1_next  = work_t'(normal_y) <<< GUARD_BITS;
                    d2_next  = work_t'(normal_z) <<< GUARD_BITS;
                    o01_next = work_t'(shear_xy) <<< GUARD_BITS;
                    o12_next = work_t'(shear_yz) <<< GUARD_BITS;
                    o02_next = work_t'(shear_zx) <<< GUARD_BITS;
                    accd_next = '0;
                    accs_next = '0;
                    cnt_next  = '0;
                    rot_next  = '0;
                    state_next = S_EQ;
                end
            end
            S_EQ:
            begin
                // Each square is registered in prod_reg and added to its sum in the following cycle.
                if (cnt_reg >= 6'd1 && cnt_reg <= 6'd3)
                    accd_next = accd_reg + 67'(prod_reg);
                else if (cnt_reg >= 6'd4)
                    accs_next = accs_reg + 66'(prod_reg);
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd6)
                    state_next = S_SQINIT;
            end
            S_SQINIT:
            begin
                rad_next  = 68'(accd_reg >> 1) + 68'(accs_reg) + (68'(accs_reg) << 1);
                rem_next  = '0;
                root_next = '0;
                cnt_next  = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (rem_t >= trial)
                begin
                    rem_next  = 36'(rem_t - trial);
                    root_next = {root_reg[OUT_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = 36'(rem_t);
                    root_next = {root_reg[OUT_WIDTH-2:0], 1'b0};
                end
                rad_next = rad_reg << 2;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(SQRT_STEPS - 1))
                    state_next = S_SEL;
            end
            S_SEL:
            begin
                if (rot_reg == ROT_CNT_WIDTH'(MAX_ROTATIONS) ||
                    big <= (WORK_WIDTH'(tol_reg) << GUARD_BITS))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    pair_next = pick;
                    sum_next  = a_sel + b_sel;
                    cnt_next  = '0;
                    if (vx0[WORK_WIDTH-1])
                    begin
                        x_next = -vx0;
                        y_next = -vy0;
                        z_next = vy0[WORK_WIDTH-1] ? -ANGLE_PI : ANGLE_PI;
                    end
                    else
                    begin
                        x_next = vx0;
                        y_next = vy0;
                        z_next = '0;
                    end
                    state_next = S_VEC;
                end
            end
            S_VEC:
            begin
                if (!y_reg[WORK_WIDTH-1] && y_reg != '0)
                begin
                    x_next = x_reg + ys; y_next = y_reg - xs; z_next = z_reg + atan_v;
                end
                else
                begin
                    x_next = x_reg - ys; y_next = y_reg + xs; z_next = z_reg - atan_v;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(CORDIC_STEPS - 1))
                begin
                    gph_next = GPH_LO;
                    state_next = S_GAIN_R;
                end
            end
            S_GAIN_R, S_GAIN_P, S_GAIN_Q:
            begin
                gph_next = gph_reg + 2'd1;
                unique case (gph_reg)
                    GPH_LO:  ;
                    GPH_HI:  accg_next = 95'(prod_reg) + (95'(1) << 29);
                    GPH_ADD: accg_next = accg_reg + (95'(prod_reg) << 32);
                    default:
                    begin
                        if (state_reg == S_GAIN_R)
                        begin
                            unique case (pair_reg)
                                PAIR_XY:
                                begin
                                    d0_next = dlo; d1_next = dhi; o01_next = '0;
                                    x_next = o02_reg; y_next = o12_reg;
                                end
                                PAIR_XZ:
                                begin
                                    d0_next = dlo; d2_next = dhi; o02_next = '0;
                                    x_next = o01_reg; y_next = o12_reg;
                                end
                                default:
                                begin
                                    d1_next = dlo; d2_next = dhi; o12_next = '0;
                                    x_next = o01_reg; y_next = o02_reg;
                                end
                            endcase
                            z_next   = z_reg >>> 1;
                            cnt_next = '0;
                            state_next = S_ROT;
                        end
                        else if (state_reg == S_GAIN_P)
                        begin
                            pres_next  = g_res;
                            state_next = S_GAIN_Q;
                        end
                        else
                        begin
                            unique case (pair_reg)
                                PAIR_XY: begin o02_next = pres_reg; o12_next = g_res; end
                                PAIR_XZ: begin o01_next = pres_reg; o12_next = g_res; end
                                default: begin o01_next = pres_reg; o02_next = g_res; end
                            endcase
                            rot_next = rot_reg + ROT_CNT_WIDTH'(1);
                            state_next = S_SEL;
                        end
                    end
                endcase
            end
            S_ROT:
            begin
                if (!z_reg[ANGLE_WIDTH-1])
                begin
                    x_next = x_reg - ys; y_next = y_reg + xs; z_next = z_reg - atan_v;
                end
                else
                begin
                    x_next = x_reg + ys; y_next = y_reg - xs; z_next = z_reg + atan_v;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(CORDIC_STEPS - 1))
                begin
                    gph_next = GPH_LO;
                    state_next = S_GAIN_P;
                end
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            gph_reg       <= GPH_LO;
            rot_reg       <= '0;
            tol_reg       <= TOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            gph_reg   <= gph_next;
            rot_reg   <= rot_next;
            if (cfg_write_en)
                tol_reg <= cfg_write_data;
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            vx_reg  <= normal_x;
            vy_reg  <= normal_y;
            vz_reg  <= normal_z;
            vxy_reg <= shear_xy;
            vyz_reg <= shear_yz;
            vzx_reg <= shear_zx;
        end
        prod_reg <= mul_a * mul_b;
        pair_reg <= pair_next;
        d0_reg <= d0_next; d1_reg <= d1_next; d2_reg <= d2_next;
        o01_reg <= o01_next; o02_reg <= o02_next; o12_reg <= o12_next;
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        sum_reg <= sum_next; pres_reg <= pres_next;
        accg_reg <= accg_next; accd_reg <= accd_next; accs_reg <= accs_next;
        rad_reg <= rad_next; rem_reg <= rem_next; root_reg <= root_next;
        if (state_reg == S_FIN && out_free)
        begin
            eq_out_reg <= root_reg;
            pmax_reg   <= round_out(s0c);
            pmid_reg   <= round_out(s1c);
            pmin_reg   <= round_out(s2b);
        end
    end

    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_valid_reg;
    assign equivalent_stress = eq_out_reg;
    assign principal_max     = pmax_reg;
    assign principal_mid     = pmid_reg;
    assign principal_min     = pmin_reg;

    // ---------------- assertions ----------------
    a_rot_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rot_reg <= ROT_CNT_WIDTH'(MAX_ROTATIONS))
        else $error("rotation count beyond limit");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_EQ)
        else $error("accepted beat did not start the sequencer");

    a_cordic_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VEC || state_reg == S_ROT) |-> cnt_reg < 6'(CORDIC_STEPS))
        else $error("CORDIC step counter overran");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && !(out_valid && out_stall) |=> out_valid && state_reg == S_IDLE)
        else $error("result not delivered after finish");

endmodule

`default_nettype wire
